// File: design/hcs_pkg.sv
// hcs_pkg: shared types and constants for the histogram contrast stretch
// no dependencies; imported by hcs_front, hcs_back, histogram_contrast_stretch and tb_histogram_contrast_stretch

package hcs_pkg;

  localparam int unsigned GREY_LEVELS_DEF = 256;
  localparam int unsigned LEVEL_W         = 8;
  localparam int unsigned BOUND_W         = 9;
  localparam logic [LEVEL_W-1:0] TOP_OUT  = 8'd255;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_MAP   = 2'd2
  } op_e;

  typedef enum logic {
    REG_LOW_BOUND  = 1'b0,
    REG_HIGH_BOUND = 1'b1
  } reg_e;

  typedef struct packed {
    op_e                op;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

endpackage

// File: design/hcs_front.sv
// hcs_front: takes requests, drops unused operations, clamps the level
// and holds them in a two-entry queue for the back end; uses hcs_pkg

module hcs_front #(
  parameter int unsigned GREY_LEVELS = hcs_pkg::GREY_LEVELS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [1:0]                  operation_i,
  input  logic [hcs_pkg::LEVEL_W-1:0] pixel_in_i,
  output logic                        busy_o,
  output logic                        cmd_valid_o,
  output hcs_pkg::cmd_t               cmd_o,
  input  logic                        cmd_ready_i
);
  import hcs_pkg::*;

  localparam int unsigned NumLevels = (GREY_LEVELS < 256) ? GREY_LEVELS : 256;
  localparam logic [LEVEL_W-1:0] TopLevel = LEVEL_W'(NumLevels - 1);

  cmd_t       queue_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic       keep;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  always_comb begin
    unique case (op_e'(operation_i)) inside
      OP_CLEAR, OP_MARK, OP_MAP: keep = 1'b1;
      default:                   keep = 1'b0;
    endcase
  end

  // levels beyond the store fold onto the top level
  assign cmd_in.op    = op_e'(operation_i);
  assign cmd_in.level = (pixel_in_i > TopLevel) ? TopLevel : pixel_in_i;

  assign busy_o      = (count_q == 2'd2);
  assign push        = start_i && !busy_o && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// File: design/hcs_back.sv
// hcs_back: carries out clear, mark and map requests; holds the occupancy
// bits, the bound registers, the table builder and the table memory; uses hcs_pkg

module hcs_back #(
  parameter int unsigned GREY_LEVELS = hcs_pkg::GREY_LEVELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_valid_i,
  input  hcs_pkg::cmd_t                      cmd_i,
  output logic                               cmd_ready_o,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_index_i,
  input  logic signed [hcs_pkg::BOUND_W-1:0] cfg_data_i,
  output logic                               done_o,
  output logic [hcs_pkg::LEVEL_W-1:0]        pixel_out_o
);
  import hcs_pkg::*;

  localparam int unsigned NumLevels = (GREY_LEVELS < 256) ? GREY_LEVELS : 256;
  localparam int unsigned IdxW      = $clog2(NumLevels);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumLevels - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_BOUND,
    ST_DIV,
    ST_FILL
  } state_e;

  state_e                    state_q;
  logic                      ready_q;
  logic [NumLevels-1:0]      seen_q;
  logic [IdxW-1:0]           idx_q;
  logic                      found_q;
  logic [LEVEL_W-1:0]        first_q;
  logic [LEVEL_W-1:0]        last_q;
  logic [LEVEL_W-1:0]        lo_q;
  logic [LEVEL_W-1:0]        hi_q;
  logic [2:0]                div_cnt_q;
  logic [LEVEL_W-1:0]        rem_q;
  logic [LEVEL_W-1:0]        quot_q;
  logic [LEVEL_W:0]          acc_q;
  logic [LEVEL_W-1:0]        acc_r_q;
  logic signed [BOUND_W-1:0] low_bound_q;
  logic signed [BOUND_W-1:0] high_bound_q;
  logic                      done_q;
  logic [LEVEL_W-1:0]        rd_data_q;
  logic [LEVEL_W-1:0]        map_mem [NumLevels];

  logic [IdxW-1:0]    lvl_idx;
  logic               is_map;
  logic               pop;
  logic               rd_en;
  logic [LEVEL_W-1:0] idx8;
  logic [LEVEL_W-1:0] diff;
  logic [LEVEL_W:0]   rem_sh;
  logic               div_ge;
  logic [LEVEL_W:0]   v9;
  logic [LEVEL_W:0]   lo9;
  logic [LEVEL_W:0]   hi9;
  logic               degen;
  logic [LEVEL_W-1:0] fill_val;
  logic [LEVEL_W:0]   sum_r;
  logic               wrap;

  assign lvl_idx     = cmd_i.level[IdxW-1:0];
  assign is_map      = (cmd_i.op == OP_MAP);
  assign cmd_ready_o = (state_q == ST_IDLE) && (!is_map || ready_q);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign rd_en       = pop && is_map;

  assign idx8   = LEVEL_W'(idx_q);
  assign diff   = hi_q - lo_q;
  assign rem_sh = {rem_q, TOP_OUT[div_cnt_q]};
  assign div_ge = (rem_sh >= {1'b0, diff});

  assign v9    = (LEVEL_W + 1)'(idx_q);
  assign lo9   = {1'b0, lo_q};
  assign hi9   = {1'b0, hi_q};
  assign degen = (hi_q <= lo_q);
  assign sum_r = {1'b0, acc_r_q} + {1'b0, rem_q};
  assign wrap  = (sum_r >= {1'b0, diff});

  always_comb begin
    if (degen) begin
      fill_val = (v9 <= lo9) ? '0 : TOP_OUT;
    end else if (v9 < lo9) begin
      fill_val = '0;
    end else if (v9 > hi9) begin
      fill_val = TOP_OUT;
    end else begin
      fill_val = acc_q[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ready_q      <= 1'b0;
      seen_q       <= '0;
      idx_q        <= '0;
      found_q      <= 1'b0;
      first_q      <= TOP_OUT;
      last_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      div_cnt_q    <= '0;
      rem_q        <= '0;
      quot_q       <= '0;
      acc_q        <= '0;
      acc_r_q      <= '0;
      low_bound_q  <= '1;
      high_bound_q <= '1;
      done_q       <= 1'b0;
    end else begin
      done_q <= rd_en;
      unique case (state_q)
        ST_IDLE: begin
          if (pop) begin
            unique case (cmd_i.op)
              OP_CLEAR: begin
                seen_q  <= '0;
                ready_q <= 1'b0;
              end
              OP_MARK: begin
                seen_q[lvl_idx] <= 1'b1;
                ready_q         <= 1'b0;
              end
              default: ;
            endcase
          end else if (cmd_valid_i && is_map && !ready_q) begin
            state_q <= ST_SCAN;
            idx_q   <= '0;
            found_q <= 1'b0;
            first_q <= TOP_OUT;
            last_q  <= '0;
          end
        end
        ST_SCAN: begin
          if (seen_q[idx_q]) begin
            if (!found_q) begin
              first_q <= idx8;
            end
            last_q  <= idx8;
            found_q <= 1'b1;
          end
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            state_q <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          lo_q      <= low_bound_q[BOUND_W-1]  ? first_q : low_bound_q[LEVEL_W-1:0];
          hi_q      <= high_bound_q[BOUND_W-1] ? last_q  : high_bound_q[LEVEL_W-1:0];
          div_cnt_q <= 3'd7;
          rem_q     <= '0;
          quot_q    <= '0;
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          // one quotient bit of 255 / (hi - lo) per cycle
          rem_q     <= div_ge ? LEVEL_W'(rem_sh - {1'b0, diff}) : rem_sh[LEVEL_W-1:0];
          quot_q    <= {quot_q[LEVEL_W-2:0], div_ge};
          div_cnt_q <= div_cnt_q - 3'd1;
          if (div_cnt_q == 3'd0) begin
            state_q <= ST_FILL;
            idx_q   <= '0;
            acc_q   <= '0;
            acc_r_q <= '0;
          end
        end
        ST_FILL: begin
          // running floor(255 * (v - lo) / (hi - lo)) from quotient and remainder
          if (v9 >= lo9) begin
            acc_q   <= acc_q + {1'b0, quot_q} + (LEVEL_W + 1)'(wrap);
            acc_r_q <= wrap ? LEVEL_W'(sum_r - {1'b0, diff}) : sum_r[LEVEL_W-1:0];
          end
          idx_q <= idx_q + IdxW'(1);
          if (idx_q == LastIdx) begin
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (cfg_valid_i) begin
        unique case (reg_e'(cfg_index_i))
          REG_LOW_BOUND:  low_bound_q  <= cfg_data_i;
          REG_HIGH_BOUND: high_bound_q <= cfg_data_i;
          default: ;
        endcase
        ready_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FILL) begin
      map_mem[idx_q] <= fill_val;
    end
    if (rd_en) begin
      rd_data_q <= map_mem[lvl_idx];
    end
  end

  assign done_o      = done_q;
  assign pixel_out_o = rd_data_q;

endmodule

// File: design/histogram_contrast_stretch.sv
// Two-pass 8-bit contrast stretch. A clear or mark request takes effect at the
// edge at which it leaves the two-entry queue; a map request with a valid table
// gives its result on pixel_out_o with done_o from the registered table read
// made as it leaves the queue, and such requests run at one per cycle while the
// back end is idle. The first map after a clear, mark or bound write rebuilds the
// table first: a scan of the occupancy bits over N = min(GREY_LEVELS, 256) levels,
// a single step to pick the bounds, eight divider steps, and a fill sweep of N
// levels through the single write port of the table memory. The receiver cannot
// stall results. busy_o is high only while the queue is full. cfg_ready_o is always
// high; bounds are to be written only while no request is outstanding.
// Depends on hcs_pkg, hcs_front and hcs_back.

module histogram_contrast_stretch #(
  parameter int unsigned GREY_LEVELS = hcs_pkg::GREY_LEVELS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic [hcs_pkg::LEVEL_W-1:0]        pixel_in_i,
  output logic                               done_o,
  output logic [hcs_pkg::LEVEL_W-1:0]        pixel_out_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic                               cfg_index_i,
  input  logic signed [hcs_pkg::BOUND_W-1:0] cfg_data_i
);
  import hcs_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  hcs_front #(
    .GREY_LEVELS (GREY_LEVELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .pixel_in_i  (pixel_in_i),
    .busy_o      (busy_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  hcs_back #(
    .GREY_LEVELS (GREY_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .pixel_out_o (pixel_out_o)
  );

`ifndef NO_ASSERTIONS
  a_done_from_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_valid && cmd_ready && cmd.op == OP_MAP))
    else $error("result strobe without a map request");

  a_map_gives_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && cmd_ready && cmd.op == OP_MAP) |=> done_o)
    else $error("map request gave no result");

  a_busy_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> cmd_valid)
    else $error("queue full but no request offered to back end");
`endif

endmodule

// File: dv/tb_histogram_contrast_stretch.sv
// tb_histogram_contrast_stretch: self-checking bench for the two-pass contrast stretch
// predicts every mapped pixel in a small scoreboard class; depends on hcs_pkg and
// histogram_contrast_stretch

`timescale 1ns / 1ps

module tb_histogram_contrast_stretch;
  import hcs_pkg::*;

  localparam int LEVELS = GREY_LEVELS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 1900;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;

  class stretch_scoreboard;
    bit         level_seen[LEVELS];
    logic [7:0] stretch_lut[LEVELS];
    bit         lut_valid;
    int         low_bound;
    int         high_bound;
    logic [7:0] expected_pixels[$];
    int         failures;

    function new();
      foreach (level_seen[i]) level_seen[i] = 1'b0;
      lut_valid  = 1'b0;
      low_bound  = -1;
      high_bound = -1;
      failures   = 0;
    endfunction

    function void write_bound(reg_e idx, logic signed [BOUND_W-1:0] value);
      if (idx == REG_LOW_BOUND) low_bound = int'(value);
      else high_bound = int'(value);
      lut_valid = 1'b0;
    endfunction

    function void note_request(logic [1:0] op, logic [7:0] px);
      int lv;
      int first_seen;
      int last_seen;
      int lo;
      int hi;
      bit found;
      lv = (int'(px) > LEVELS - 1) ? LEVELS - 1 : int'(px);
      case (op)
        OP_CLEAR: begin
          foreach (level_seen[i]) level_seen[i] = 1'b0;
          lut_valid = 1'b0;
        end
        OP_MARK: begin
          level_seen[lv] = 1'b1;
          lut_valid = 1'b0;
        end
        OP_MAP: begin
          if (!lut_valid) begin
            // bounds: register value, or occupied extremes when negative
            found = 1'b0;
            first_seen = 255;
            last_seen = 0;
            for (int v = 0; v < LEVELS; v++) begin
              if (level_seen[v]) begin
                if (!found) first_seen = v;
                last_seen = v;
                found = 1'b1;
              end
            end
            lo = (low_bound < 0) ? first_seen : (low_bound & 255);
            hi = (high_bound < 0) ? last_seen : (high_bound & 255);
            for (int v = 0; v < LEVELS; v++) begin
              if (hi <= lo) stretch_lut[v] = (v <= lo) ? 8'd0 : TOP_OUT;
              else if (v < lo) stretch_lut[v] = 8'd0;
              else if (v > hi) stretch_lut[v] = TOP_OUT;
              else stretch_lut[v] = 8'((255 * (v - lo)) / (hi - lo));
            end
            lut_valid = 1'b1;
          end
          expected_pixels.push_back(stretch_lut[lv]);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [7:0] got);
      logic [7:0] want;
      if (expected_pixels.size() == 0) begin
        $error("pixel_out expected none actual %0d", got);
        failures++;
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          $error("pixel_out expected %0d actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [1:0]                operation_i;
  logic [LEVEL_W-1:0]        pixel_in_i;
  logic                      done_o;
  logic [LEVEL_W-1:0]        pixel_out_o;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic                      cfg_index_i;
  logic signed [BOUND_W-1:0] cfg_data_i;

  stretch_scoreboard sb = new();
  int sent_count = 0;
  int gap_max = 7;
  int cycle_count = 0;

  histogram_contrast_stretch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .operation_i (operation_i),
    .pixel_in_i  (pixel_in_i),
    .done_o      (done_o),
    .pixel_out_o (pixel_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_result(pixel_out_o);
      if (cfg_valid_i && cfg_ready_o) sb.write_bound(reg_e'(cfg_index_i), cfg_data_i);
      if (start_i && !busy_o) sb.note_request(operation_i, pixel_in_i);
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [7:0] px);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    pixel_in_i  <= px;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    if (op != OP_UNUSED) sent_count++;
  endtask

  // hold off until every mapped pixel is back and queued marks have landed
  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_pixels.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves valid high; the caller drops it after the last write
  task automatic write_bound(input reg_e idx, input logic signed [BOUND_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic run_frame();
    int lo_w;
    int hi_w;
    int tmp;
    int n_marks;
    int n_maps;
    lo_w = $urandom_range(255, 0);
    hi_w = $urandom_range(255, 0);
    if (lo_w > hi_w) begin
      tmp = lo_w;
      lo_w = hi_w;
      hi_w = tmp;
    end
    gap_max = ($urandom_range(3, 0) == 0) ? 0 : 7;
    send_request(OP_CLEAR, 8'($urandom));
    n_marks = $urandom_range(12, 0);
    repeat (n_marks) begin
      if ($urandom_range(9, 0) == 0) send_request(2'($urandom_range(3, 0)), 8'($urandom));
      send_request(OP_MARK, 8'($urandom_range(hi_w, lo_w)));
    end
    n_maps = $urandom_range(30, 8);
    repeat (n_maps) begin
      if ($urandom_range(9, 0) == 0) send_request(2'($urandom_range(3, 0)), 8'($urandom));
      if ($urandom_range(1, 0) == 1) send_request(OP_MAP, 8'($urandom_range(hi_w, lo_w)));
      else send_request(OP_MAP, 8'($urandom));
    end
  endtask

  initial begin
    int phase;
    int n_frames;
    logic signed [BOUND_W-1:0] lo_val;
    logic signed [BOUND_W-1:0] hi_val;

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    operation_i <= OP_CLEAR;
    pixel_in_i  <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_LOW_BOUND;
    cfg_data_i  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, full range, single level, unused operation
    send_request(OP_MAP, 8'd0);
    send_request(OP_MAP, 8'd255);
    send_request(OP_MARK, 8'd0);
    send_request(OP_MARK, 8'd255);
    send_request(OP_MAP, 8'd0);
    send_request(OP_MAP, 8'd255);
    send_request(OP_MAP, 8'd128);
    send_request(OP_MAP, 8'd1);
    send_request(OP_CLEAR, 8'd255);
    send_request(OP_UNUSED, 8'd255);
    send_request(OP_MARK, 8'd7);
    send_request(OP_MAP, 8'd7);
    send_request(OP_MAP, 8'd6);
    send_request(OP_MAP, 8'd8);
    send_request(OP_MARK, 8'd200);
    send_request(OP_MAP, 8'd100);
    send_request(OP_MAP, 8'd201);
    send_request(OP_MAP, 8'd200);
    send_request(OP_UNUSED, 8'd0);
    send_request(OP_MAP, 8'd199);

    phase = 0;
    while (sent_count < ITEM_TARGET) begin
      wait_drained();
      case (phase)
        0: begin lo_val = 9'sd0;    hi_val = 9'sd255; end
        1: begin lo_val = 9'sd255;  hi_val = 9'sd0;   end
        2: begin lo_val = -9'sd256; hi_val = -9'sd1;  end
        3: begin lo_val = -9'sd1;   hi_val = 9'sd255; end
        4: begin lo_val = 9'sd100;  hi_val = 9'sd100; end
        5: begin lo_val = -9'sd1;   hi_val = -9'sd1;  end
        default: begin
          lo_val = ($urandom_range(2, 0) == 0) ? -9'sd1 : 9'($urandom_range(255, 0));
          hi_val = ($urandom_range(2, 0) == 0) ? -9'sd1 : 9'($urandom_range(255, 0));
        end
      endcase
      if ($urandom_range(1, 0) == 1) begin
        write_bound(REG_LOW_BOUND, lo_val);
        write_bound(REG_HIGH_BOUND, hi_val);
      end else begin
        write_bound(REG_HIGH_BOUND, hi_val);
        write_bound(REG_LOW_BOUND, lo_val);
      end
      cfg_valid_i <= 1'b0;
      n_frames = $urandom_range(4, 1);
      repeat (n_frames) begin
        run_frame();
        if ($urandom_range(4, 0) == 0) wait_drained();
      end
      phase++;
    end

    start_i <= 1'b0;
    while (sb.expected_pixels.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.expected_pixels.size() > 0) begin
      $error("pixel_out results outstanding %0d", sb.expected_pixels.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
